// ----- design/ial_pkg.sv -----
// Shared action codes, status codes and types for the indexed array list.
package ial_pkg;

   localparam int unsigned CAPACITY_DEFAULT = 16;

   localparam int unsigned ACTION_W = 3;
   localparam int unsigned POSITION_W = 5;
   localparam int unsigned VALUE_W = 32;
   localparam int unsigned COUNT_OUT_W = 5;
   localparam int unsigned STATUS_W = 2;

   localparam logic [ACTION_W-1:0] ACT_PUSH_BACK  = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_POP_BACK   = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_PUSH_FRONT = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_POP_FRONT  = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_INSERT     = 3'd4;
   localparam logic [ACTION_W-1:0] ACT_ERASE      = 3'd5;
   localparam logic [ACTION_W-1:0] ACT_READ       = 3'd6;

   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd2;
   localparam logic [STATUS_W-1:0] ST_BAD_IDX = 2'd3;

   typedef struct packed {
      logic insert;
      logic remove;
   } store_cmd_type;

endpackage

// ----- design/ial_store.sv -----
// Row of entry cells that shift up, shift down, load or hold.
module ial_store
   import ial_pkg::*;
#(
   parameter int unsigned CAPACITY = CAPACITY_DEFAULT,
   localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
   input  logic                 clock,
   input  store_cmd_type        cmd,
   input  logic [IDX_W-1:0]     cmd_index,
   input  logic [VALUE_W-1:0]   cmd_value,
   input  logic [IDX_W-1:0]     rd_index,
   output logic [VALUE_W-1:0]   rd_data
);

   logic [VALUE_W-1:0] entry_ff [CAPACITY];

   for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
      logic [VALUE_W-1:0] entry_in;
      logic               at_index;
      logic               above_index;

      assign at_index = (IDX_W'(k) == cmd_index);
      assign above_index = (IDX_W'(k) > cmd_index);

      always_comb begin
         entry_in = entry_ff[k];
         if (cmd.insert) begin
            if (at_index) begin
               entry_in = cmd_value;
            end else if (above_index) begin
               if (k > 0) begin
                  entry_in = entry_ff[(k > 0) ? k - 1 : 0];
               end
            end
         end else if (cmd.remove) begin
            if (at_index || above_index) begin
               if (k + 1 < CAPACITY) begin
                  entry_in = entry_ff[(k + 1 < CAPACITY) ? k + 1 : k];
               end
            end
         end
      end

      always_ff @(posedge clock) begin
         entry_ff[k] <= entry_in;
      end
   end

   assign rd_data = entry_ff[rd_index];

endmodule

// ----- design/indexed_array_list_core.sv -----
// Top level of the indexed array list: action decode, fill count and result register.
// A response item is registered and appears in the cycle after its request item is accepted.
// Throughput: one item per cycle while responses are taken; every cell shifts, loads or holds in parallel.
// A request is taken while the response register is empty or being emptied.
// Reset clears the fill count and the response valid flag; entries stay undefined.
module indexed_array_list_core
   import ial_pkg::*;
#(
   parameter int unsigned CAPACITY = CAPACITY_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // action [2:0], position [7:3], value [39:8]
   input  logic [39:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // read_value [31:0], item_count [36:32], status [38:37], zero [39]
   output logic [39:0] rsp_tdata
);

   localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
   localparam int unsigned CMP_W = (CNT_W > POSITION_W) ? CNT_W : POSITION_W;

   logic [ACTION_W-1:0]   action;
   logic [POSITION_W-1:0] position;
   logic [VALUE_W-1:0]    value;
   logic                  req_accept;

   logic [CNT_W-1:0]      count_ff;
   logic [CNT_W-1:0]      count_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [39:0]           rsp_data_ff;
   logic [39:0]           rsp_data_in;

   logic [CMP_W-1:0]      pos_ext;
   logic [CMP_W-1:0]      cnt_ext;
   logic                  full;
   logic                  empty;
   logic [STATUS_W-1:0]   status_in;
   logic                  read_ok;
   store_cmd_type         cmd_sel;
   store_cmd_type         cmd;
   logic [CMP_W-1:0]      cmd_pos;
   logic [VALUE_W-1:0]    rd_data;
   logic [VALUE_W-1:0]    read_value_in;
   logic [CMP_W-1:0]      count_out_ext;

   assign action = req_tdata[2:0];
   assign position = req_tdata[7:3];
   assign value = req_tdata[39:8];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   assign pos_ext = CMP_W'(position);
   assign cnt_ext = CMP_W'(count_ff);
   assign full = (count_ff == CNT_W'(CAPACITY));
   assign empty = (count_ff == '0);

   always_comb begin
      status_in = ST_OK;
      read_ok = 1'b0;
      cmd_sel = '0;
      cmd_pos = '0;
      count_in = count_ff;
      unique case (action)
         ACT_PUSH_BACK, ACT_PUSH_FRONT: begin
            if (full) begin
               status_in = ST_FULL;
            end else begin
               cmd_sel.insert = 1'b1;
               cmd_pos = (action == ACT_PUSH_BACK) ? cnt_ext : '0;
               count_in = count_ff + 1'b1;
            end
         end
         ACT_POP_BACK: begin
            if (empty) begin
               status_in = ST_EMPTY;
            end else begin
               count_in = count_ff - 1'b1;
            end
         end
         ACT_POP_FRONT: begin
            if (empty) begin
               status_in = ST_EMPTY;
            end else begin
               cmd_sel.remove = 1'b1;
               count_in = count_ff - 1'b1;
            end
         end
         ACT_INSERT: begin
            if (pos_ext > cnt_ext) begin
               status_in = ST_BAD_IDX;
            end else if (full) begin
               status_in = ST_FULL;
            end else begin
               cmd_sel.insert = 1'b1;
               cmd_pos = pos_ext;
               count_in = count_ff + 1'b1;
            end
         end
         ACT_ERASE: begin
            if (empty) begin
               status_in = ST_EMPTY;
            end else if (pos_ext >= cnt_ext) begin
               status_in = ST_BAD_IDX;
            end else begin
               cmd_sel.remove = 1'b1;
               cmd_pos = pos_ext;
               count_in = count_ff - 1'b1;
            end
         end
         ACT_READ: begin
            if (empty) begin
               status_in = ST_EMPTY;
            end else if (pos_ext >= cnt_ext) begin
               status_in = ST_BAD_IDX;
            end else begin
               read_ok = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   assign cmd = req_accept ? cmd_sel : '0;

   ial_store #(
      .CAPACITY(CAPACITY)
   ) u_store (
      .clock     (clock),
      .cmd       (cmd),
      .cmd_index (cmd_pos[IDX_W-1:0]),
      .cmd_value (value),
      .rd_index  (pos_ext[IDX_W-1:0]),
      .rd_data   (rd_data)
   );

   assign read_value_in = read_ok ? rd_data : '0;
   assign count_out_ext = CMP_W'(count_in);
   assign rsp_data_in = {1'b0, status_in, count_out_ext[COUNT_OUT_W-1:0], read_value_in};

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_accept) begin
            count_ff <= count_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      CMP_W'(count_ff) <= CMP_W'(CAPACITY))
      else $error("fill count exceeds capacity");

   a_count_idle: assert property (@(posedge clock) disable iff (reset)
      !req_accept |=> $stable(count_ff))
      else $error("fill count changed without an accepted item");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      req_accept && status_in == ST_OK &&
      (action == ACT_PUSH_BACK || action == ACT_PUSH_FRONT || action == ACT_INSERT)
      |=> count_ff == CNT_W'($past(count_ff) + 1'b1))
      else $error("successful insertion did not grow the list by one");

   a_error_holds: assert property (@(posedge clock) disable iff (reset)
      req_accept && status_in != ST_OK |=> $stable(count_ff))
      else $error("failed item changed the fill count");

endmodule
